FILE: design/wbps_pkg.sv
// wbps_pkg: shared types and constants for the wildcard byte pattern search.
// Field widths, command and register codes, and the window control struct.
// No dependencies.
package wbps_pkg;

  localparam int OFS_W     = 12;
  localparam int START_W   = 13;
  localparam int DLEN_W    = 13;
  localparam int LEN_W     = 5;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam int PAT_W     = 128;
  localparam int WILD_W    = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WILD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DLEN   = 3'd4;

  typedef struct packed {
    logic       clear;
    logic       shift;
    logic [7:0] data;
  } win_ctrl_t;

endpackage

FILE: design/wildcard_byte_pattern_search.sv
// Wildcard byte pattern search: top level with byte buffer memory and scan control (wbps_pkg, wbps_window).
// Load: busy stays low, so load transfers can follow back to back. Search: reads run from the start
// offset up to the match or the end of the data before the result strobe; a miss with nonzero start
// adds a pass from offset zero; one memory read per cycle. Results cannot be stalled. Synchronous
// active-low reset clears control state, config registers and match history; result fields and
// buffer contents are undefined until written.
module wildcard_byte_pattern_search #(
  parameter int DATA_DEPTH  = 4096,
  parameter int PATTERN_MAX = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [wbps_pkg::CMD_W-1:0]       in_command,
  input  logic [wbps_pkg::OFS_W-1:0]       in_byte_address,
  input  logic [7:0]                       in_byte_value,
  input  logic [wbps_pkg::START_W-1:0]     in_start_offset,
  output logic                             out_valid,
  output logic                             out_found,
  output logic [wbps_pkg::OFS_W-1:0]       out_match_offset,
  output logic [wbps_pkg::OFS_W-1:0]       out_match_end,
  output logic [wbps_pkg::LEN_W-1:0]       out_match_length,
  output logic                             out_wrapped,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wbps_pkg::CFG_DAT_W-1:0]   cfg_data
);

  localparam int AW  = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int DLW = $clog2(DATA_DEPTH + 1);
  localparam int CW  = (DLW > wbps_pkg::START_W) ? DLW : wbps_pkg::START_W;
  localparam int LW  = wbps_pkg::LEN_W;
  localparam int OW  = wbps_pkg::OFS_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;

  logic [7:0] data_mem [DATA_DEPTH];

  logic [1:0]                    state_r, state_nxt;
  logic [wbps_pkg::PAT_W-1:0]    pattern_r;
  logic [wbps_pkg::WILD_W-1:0]   wild_r;
  logic [LW-1:0]                 plen_cfg_r;
  logic [wbps_pkg::DLEN_W-1:0]   dlen_cfg_r;
  logic [CW-1:0]                 issue_r, issue_nxt;
  logic                          rd_pend_r;
  logic [CW-1:0]                 rd_pos_r;
  logic [7:0]                    rdata_r;
  logic [CW-1:0]                 win_end_r;
  logic                          pass_r, pass_nxt;
  logic                          start_nz_r, start_nz_nxt;
  logic                          has_last_r, has_last_nxt;
  logic [OW-1:0]                 last_r, last_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [OW-1:0]                 out_ofs_r, out_ofs_nxt;
  logic [OW-1:0]                 out_end_r, out_end_nxt;
  logic [LW-1:0]                 out_len_r, out_len_nxt;
  logic                          out_wrap_r, out_wrap_nxt;

  logic                          accept;
  logic                          load_wr;
  logic [CW-1:0]                 load_addr;
  logic [CW-1:0]                 dlen_sat;
  logic [LW-1:0]                 plen;
  logic                          rd_en;
  logic                          hit;
  logic [CW-1:0]                 hit_pos;
  logic [wbps_pkg::START_W-1:0]  search_start;
  logic                          clear_win;
  wbps_pkg::win_ctrl_t           win_ctrl;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_ofs_r;
  assign out_match_end    = out_end_r;
  assign out_match_length = out_len_r;
  assign out_wrapped      = out_wrap_r;

  assign dlen_sat = (CW'(dlen_cfg_r) > CW'(DATA_DEPTH)) ? CW'(DATA_DEPTH) : CW'(dlen_cfg_r);
  assign plen     = (plen_cfg_r > LW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : plen_cfg_r;

  assign load_addr = CW'(in_byte_address);
  assign load_wr   = accept && in_command == wbps_pkg::CMD_LOAD
                     && load_addr < CW'(DATA_DEPTH);

  assign rd_en   = (state_r == ST_SCAN) && (issue_r < dlen_sat);
  assign hit_pos = win_end_r - CW'(plen) + CW'(1);

  always_comb begin
    if (in_command == wbps_pkg::CMD_SEARCH) begin
      search_start = in_start_offset;
    end else if (has_last_r) begin
      search_start = {1'b0, last_r} + wbps_pkg::START_W'(1);
    end else begin
      search_start = '0;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r  <= '0;
      wild_r     <= '0;
      plen_cfg_r <= '0;
      dlen_cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wbps_pkg::CFG_PAT_LO: pattern_r[63:0]   <= cfg_data;
        wbps_pkg::CFG_PAT_HI: pattern_r[127:64] <= cfg_data;
        wbps_pkg::CFG_WILD:   wild_r     <= cfg_data[wbps_pkg::WILD_W-1:0];
        wbps_pkg::CFG_PLEN:   plen_cfg_r <= cfg_data[LW-1:0];
        wbps_pkg::CFG_DLEN:   dlen_cfg_r <= cfg_data[wbps_pkg::DLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // buffer memory: one write port for loads, one registered read port for scans
  always_ff @(posedge clk) begin
    if (load_wr) begin
      data_mem[load_addr[AW-1:0]] <= in_byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= data_mem[issue_r[AW-1:0]];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    pass_nxt      = pass_r;
    start_nz_nxt  = start_nz_r;
    has_last_nxt  = has_last_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_ofs_nxt   = out_ofs_r;
    out_end_nxt   = out_end_r;
    out_len_nxt   = out_len_r;
    out_wrap_nxt  = out_wrap_r;
    clear_win     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_command == wbps_pkg::CMD_SEARCH
                       || in_command == wbps_pkg::CMD_NEXT)) begin
          state_nxt    = ST_SCAN;
          issue_nxt    = CW'(search_start);
          pass_nxt     = 1'b0;
          start_nz_nxt = (search_start != '0);
          clear_win    = 1'b1;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          issue_nxt = issue_r + CW'(1);
        end
        if (hit) begin
          state_nxt     = ST_IDLE;
          has_last_nxt  = 1'b1;
          last_nxt      = hit_pos[OW-1:0];
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_ofs_nxt   = hit_pos[OW-1:0];
          out_end_nxt   = win_end_r[OW-1:0];
          out_len_nxt   = plen;
          out_wrap_nxt  = pass_r;
        end else if (!rd_en && !rd_pend_r) begin
          if (!pass_r && start_nz_r) begin
            // miss with nonzero start: rescan from offset zero
            issue_nxt = '0;
            pass_nxt  = 1'b1;
            clear_win = 1'b1;
          end else begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            out_ofs_nxt   = '0;
            out_end_nxt   = '0;
            out_len_nxt   = '0;
            out_wrap_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      has_last_r  <= 1'b0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      pass_r      <= 1'b0;
      start_nz_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_en;
      has_last_r  <= has_last_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      pass_r      <= pass_nxt;
      start_nz_r  <= start_nz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_r     <= issue_nxt;
    out_found_r <= out_found_nxt;
    out_ofs_r   <= out_ofs_nxt;
    out_end_r   <= out_end_nxt;
    out_len_r   <= out_len_nxt;
    out_wrap_r  <= out_wrap_nxt;
    if (rd_en) begin
      rd_pos_r <= issue_r;
    end
    if (rd_pend_r) begin
      win_end_r <= rd_pos_r;
    end
  end

  assign win_ctrl.clear = clear_win;
  assign win_ctrl.shift = rd_pend_r;
  assign win_ctrl.data  = rdata_r;

  wbps_window #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (win_ctrl),
    .plen    (plen),
    .pattern (pattern_r),
    .wild    (wild_r),
    .hit     (hit)
  );

`ifndef NO_ASSERTIONS
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still scanning");

  a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_match_length != '0)
    else $error("match reported with zero length");

  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> !out_wrapped && out_match_length == '0)
    else $error("miss result carries match fields");

  a_load_nobusy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == wbps_pkg::CMD_LOAD |=> !busy && !out_valid)
    else $error("load transfer started a scan or result");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r == ST_SCAN))
    else $error("buffer read outside a scan");
`endif

endmodule

FILE: design/wbps_window.sv
// wbps_window: sliding window of the most recent buffer bytes and the
// wildcard compare against the pattern. Depends on wbps_pkg.
module wbps_window #(
  parameter int PATTERN_MAX = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wbps_pkg::win_ctrl_t          ctrl,
  input  logic [wbps_pkg::LEN_W-1:0]   plen,
  input  logic [wbps_pkg::PAT_W-1:0]   pattern,
  input  logic [wbps_pkg::WILD_W-1:0]  wild,
  output logic                         hit
);

  localparam int LW = wbps_pkg::LEN_W;

  logic [7:0]    win_r   [PATTERN_MAX];
  logic [7:0]    win_nxt [PATTERN_MAX];
  logic [LW-1:0] fill_r;
  logic [LW-1:0] fill_nxt;
  logic [LW-1:0] top_idx;

  // newest byte lands at plen-1, older bytes move toward index 0
  assign top_idx = plen - LW'(1);

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (LW'(k) == top_idx) begin
        win_nxt[k] = ctrl.data;
      end else if (k < PATTERN_MAX - 1) begin
        win_nxt[k] = win_r[(k < PATTERN_MAX - 1) ? k + 1 : k];
      end else begin
        win_nxt[k] = win_r[k];
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (ctrl.clear) begin
      fill_nxt = '0;
    end else if (ctrl.shift && fill_r != LW'(PATTERN_MAX)) begin
      fill_nxt = fill_r + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift && !ctrl.clear) begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    hit = (plen != '0) && (fill_r >= plen);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LW'(i) < plen && !wild[i] && win_r[i] != pattern[8*i +: 8]) begin
        hit = 1'b0;
      end
    end
  end

endmodule
